### rtl/core/haptic_pattern_sequencer_assert.svh
// Assertion macros for the haptic pattern sequencer.
// Used by modules in rtl/core; assertions compile away when NO_ASSERTIONS is set.
`ifndef HAPTIC_PATTERN_SEQUENCER_ASSERT_SVH
`define HAPTIC_PATTERN_SEQUENCER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Clocked property that is ignored while reset is high.
`define HPS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked property that is checked in reset as well.
`define HPS_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HPS_ASSERT(lbl, clk, rst, prop, msg)
`define HPS_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

### rtl/core/hps_pkg.sv
// Shared types, codes and constants of the haptic pattern sequencer.
// No dependencies; imported by every module in rtl/core.
package hps_pkg;

   localparam int MAX_SEGMENTS = 16;
   localparam int SEG_IDX_W    = $clog2(MAX_SEGMENTS);
   localparam int SEG_CNT_W    = 5;
   localparam int PROBE_RESET  = 250;

   localparam logic [6:0] AMP_MAX = 7'd100;

   // Item kinds.
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_LOAD  = 2'd2;

   // Result status codes.
   localparam logic [1:0] STAT_NONE      = 2'd0;
   localparam logic [1:0] STAT_ACCEPTED  = 2'd1;
   localparam logic [1:0] STAT_REJECTED  = 2'd2;
   localparam logic [1:0] STAT_COMPLETED = 2'd3;

   // Result error codes.
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_INVALID = 2'd1;
   localparam logic [1:0] ERR_DRIVER  = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SEGMENT_COUNT  = 2'd0;
   localparam logic [1:0] CSR_REPEAT_GAP     = 2'd1;
   localparam logic [1:0] CSR_PROBE_INTERVAL = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] now_ms;
      logic        driver_present;
      logic [7:0]  repeat_count;
      logic [1:0]  intensity;
      logic [3:0]  seg_index;
      logic [6:0]  seg_amplitude;
      logic [15:0] seg_duration_ms;
   } req_word_type;

   typedef struct packed {
      logic [1:0] status;
      logic [1:0] error;
      logic       drive_update;
      logic [6:0] drive_amplitude;
      logic [1:0] drive_intensity;
      logic       playing;
   } rsp_word_type;

   typedef struct packed {
      logic [6:0]  amplitude;
      logic [15:0] duration_ms;
   } seg_entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
   } hps_cmd_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } ctrl_state_type;

endpackage

### rtl/core/haptic_pattern_sequencer.sv
// Top level of the haptic pattern sequencer.
// Depends on hps_pkg, hps_ctrl and hps_datapath.
//
// The sequencer plays a vibration pattern from a table of up to MAX_SEGMENTS
// segments, each an amplitude and a duration, and repeats it with a silent gap
// between plays. Each request word is a millisecond tick, a start command or a
// segment load, and each gives exactly one response word with status, error,
// any new drive amplitude and the playing flag. A request word is handled in
// a capture step, which also reads the segment memory, then an execute step,
// which updates the playback state and loads the response register. A new
// request word is taken when the response register is empty or is being
// taken in the same cycle, and never before the last word has executed. The
// segment memory has no reset; a start must not run over slots never loaded.
// Configuration writes are always taken and must only be issued while no
// request word is in flight; index 0 is the segment count, 1 the repeat gap
// and 2 the probe interval, and other indexes are ignored.
module haptic_pattern_sequencer import hps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   hps_cmd_type cmd;

   // The controller sequences each word through capture and execute.
   hps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // The datapath holds configuration, playback state and the segment memory.
   hps_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_word  (req_word),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Configuration registers take a write in any cycle.
   assign csr_ready = 1'b1;

endmodule

### rtl/core/hps_ctrl.sv
// Controller of the haptic pattern sequencer: item handshake and result valid.
// Depends on hps_pkg and haptic_pattern_sequencer_assert.svh.
`include "haptic_pattern_sequencer_assert.svh"

module hps_ctrl import hps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output hps_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            // A word is taken only when the result register is free by the next edge.
            req_ready   = !rsp_valid_ff || rsp_ready;
            cmd.capture = req_valid && req_ready;
            if (cmd.capture) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute  = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `HPS_ASSERT(a_exec_single, clock, reset, state_ff == S_EXEC |=> state_ff == S_IDLE, "execute held")
   `HPS_ASSERT(a_exec_out_free, clock, reset, state_ff == S_EXEC |-> !rsp_valid_ff, "result busy")
   `HPS_ASSERT(a_exec_result, clock, reset, state_ff == S_EXEC |=> rsp_valid_ff, "result missing")
   `HPS_ASSERT(a_capture_exec, clock, reset, cmd.capture |=> state_ff == S_EXEC, "capture lost")

endmodule

### rtl/core/hps_datapath.sv
// Datapath of the haptic pattern sequencer: configuration, playback state,
// segment memory and result register. Depends on hps_pkg.
module hps_datapath import hps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  hps_cmd_type  cmd,
   input  req_word_type req_word,
   output rsp_word_type rsp_word,
   input  logic         csr_valid,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   // Configuration.
   logic [SEG_CNT_W-1:0] seg_cnt_ff;
   logic [15:0]          gap_ff;
   logic [15:0]          probe_ff;

   // Playback state.
   logic                 active_ff, active_in;
   logic                 waiting_ff, waiting_in;
   logic [SEG_CNT_W-1:0] cur_seg_ff, cur_seg_in;
   logic [7:0]           reps_ff, reps_in;
   logic [31:0]          deadline_ff, deadline_in;
   logic [31:0]          last_probe_ff, last_probe_in;
   logic                 drv_ready_ff, drv_ready_in;
   logic [1:0]           run_int_ff, run_int_in;

   // Captured word, segment read data and result.
   req_word_type         req_ff;
   seg_entry_type        rd_ff;
   rsp_word_type         rsp_ff, rsp_in;

   seg_entry_type        seg_mem [MAX_SEGMENTS];

   logic [SEG_CNT_W-1:0] next_seg;
   logic [SEG_CNT_W-1:0] used_cnt;
   logic [SEG_IDX_W-1:0] rd_addr;
   logic [31:0]          probe_diff;
   logic [31:0]          dl_diff;
   logic [31:0]          seg_dl;
   logic [31:0]          gap_dl;
   logic                 probe_due;
   logic                 dl_reached;
   logic                 fault;
   logic                 load_ok;
   logic [6:0]           load_amp;

   assign next_seg = cur_seg_ff + 1'b1;
   assign used_cnt = (32'(seg_cnt_ff) > MAX_SEGMENTS) ? SEG_CNT_W'(MAX_SEGMENTS) : seg_cnt_ff;

   // A tick that is not in the repeat gap may open the next segment; all else opens segment 0.
   always_comb begin
      rd_addr = '0;
      if (req_word.kind == KIND_TICK && !waiting_ff && 32'(next_seg) < MAX_SEGMENTS) begin
         rd_addr = SEG_IDX_W'(next_seg);
      end
   end

   assign load_ok  = 32'(req_ff.seg_index) < MAX_SEGMENTS;
   assign load_amp = (req_ff.seg_amplitude > AMP_MAX) ? AMP_MAX : req_ff.seg_amplitude;

   always_ff @(posedge clock) begin
      if (cmd.execute && req_ff.kind == KIND_LOAD && load_ok) begin
         seg_mem[SEG_IDX_W'(req_ff.seg_index)] <= {load_amp, req_ff.seg_duration_ms};
      end
      if (cmd.capture) begin
         rd_ff <= seg_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_word;
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_cnt_ff <= '0;
         gap_ff     <= '0;
         probe_ff   <= 16'(PROBE_RESET);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SEGMENT_COUNT:  seg_cnt_ff <= csr_wdata[SEG_CNT_W-1:0];
            CSR_REPEAT_GAP:     gap_ff     <= csr_wdata;
            CSR_PROBE_INTERVAL: probe_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         waiting_ff    <= 1'b0;
         cur_seg_ff    <= '0;
         reps_ff       <= '0;
         deadline_ff   <= '0;
         last_probe_ff <= '0;
         drv_ready_ff  <= 1'b1;
         run_int_ff    <= '0;
      end else if (cmd.execute) begin
         active_ff     <= active_in;
         waiting_ff    <= waiting_in;
         cur_seg_ff    <= cur_seg_in;
         reps_ff       <= reps_in;
         deadline_ff   <= deadline_in;
         last_probe_ff <= last_probe_in;
         drv_ready_ff  <= drv_ready_in;
         run_int_ff    <= run_int_in;
      end
   end

   // Deadlines count as reached when the wrapping difference is not negative.
   assign probe_diff = req_ff.now_ms - last_probe_ff - {16'd0, probe_ff};
   assign dl_diff    = req_ff.now_ms - deadline_ff;
   assign probe_due  = !probe_diff[31];
   assign dl_reached = !dl_diff[31];
   assign seg_dl     = req_ff.now_ms + {16'd0, rd_ff.duration_ms};
   assign gap_dl     = req_ff.now_ms + {16'd0, gap_ff};

   always_comb begin
      active_in     = active_ff;
      waiting_in    = waiting_ff;
      cur_seg_in    = cur_seg_ff;
      reps_in       = reps_ff;
      deadline_in   = deadline_ff;
      last_probe_in = last_probe_ff;
      drv_ready_in  = drv_ready_ff;
      run_int_in    = run_int_ff;
      fault         = 1'b0;
      rsp_in        = '0;
      rsp_in.status = STAT_NONE;
      rsp_in.error  = ERR_NONE;

      if (req_ff.kind == KIND_START) begin
         rsp_in.status = STAT_REJECTED;
         if (active_ff) begin
            rsp_in.error = ERR_INVALID;
         end else if (!drv_ready_ff || !req_ff.driver_present) begin
            drv_ready_in = 1'b0;
            rsp_in.error = ERR_DRIVER;
         end else if (used_cnt == '0) begin
            rsp_in.error = ERR_INVALID;
         end else begin
            rsp_in.status          = STAT_ACCEPTED;
            waiting_in             = 1'b0;
            cur_seg_in             = '0;
            reps_in                = req_ff.repeat_count;
            run_int_in             = req_ff.intensity;
            last_probe_in          = req_ff.now_ms;
            active_in              = 1'b1;
            rsp_in.drive_update    = 1'b1;
            rsp_in.drive_amplitude = rd_ff.amplitude;
            deadline_in            = seg_dl;
         end
      end else if (req_ff.kind == KIND_TICK && active_ff) begin
         if (probe_due) begin
            last_probe_in = req_ff.now_ms;
            if (!req_ff.driver_present) begin
               active_in     = 1'b0;
               drv_ready_in  = 1'b0;
               rsp_in.status = STAT_REJECTED;
               rsp_in.error  = ERR_DRIVER;
               fault         = 1'b1;
            end
         end
         if (!fault && dl_reached) begin
            rsp_in.drive_update = 1'b1;
            if (waiting_ff) begin
               waiting_in             = 1'b0;
               cur_seg_in             = '0;
               rsp_in.drive_amplitude = rd_ff.amplitude;
               deadline_in            = seg_dl;
            end else begin
               cur_seg_in = next_seg;
               if (next_seg < used_cnt) begin
                  rsp_in.drive_amplitude = rd_ff.amplitude;
                  deadline_in            = seg_dl;
               end else if (reps_ff > 8'd1) begin
                  reps_in     = reps_ff - 8'd1;
                  waiting_in  = 1'b1;
                  deadline_in = gap_dl;
               end else begin
                  active_in     = 1'b0;
                  rsp_in.status = STAT_COMPLETED;
               end
            end
         end
      end

      rsp_in.drive_intensity = run_int_in;
      rsp_in.playing         = active_in;
   end

   assign rsp_word = rsp_ff;

endmodule

### verif/haptic_pattern_sequencer_tb.sv
// Self-checking testbench for the haptic pattern sequencer: request, response and CSR
// channels, with an in-file playback predictor and response scoreboard.
// Depends on hps_pkg and the haptic_pattern_sequencer RTL only.
`timescale 1ns / 100ps

module haptic_pattern_sequencer_tb import hps_pkg::*; ();

   // Kind code 3 has no name in the package; the block must ignore it.
   localparam logic [1:0] KIND_RESERVED = 2'd3;
   // Index 3 of the CSR port selects no register and must be ignored.
   localparam logic [1:0] CSR_UNUSED    = 2'd3;

   // The receiver holds off this long once, when this many response words have come.
   localparam int LONG_STALL = 160;
   localparam int STALL_AT   = 250;
   // A watchdog limit for about 1100 words, with a wide margin.
   localparam int RUN_LIMIT  = 400000;

   // Playback predictor and response scoreboard. note_request() advances the
   // predicted playback state by one accepted request word and queues the
   // response word it must produce; check_response() compares a taken response
   // word against the oldest one queued.
   class hps_scoreboard;
      logic [4:0]    seg_count;
      logic [15:0]   gap_ms;
      logic [15:0]   probe_ms;
      bit            playing;
      bit            in_gap;
      logic [4:0]    seg_pos;
      logic [7:0]    plays_left;
      logic [31:0]   due_ms;
      logic [31:0]   probe_base_ms;
      bit            drv_ok;
      logic [1:0]    run_level;
      seg_entry_type pattern [MAX_SEGMENTS];
      rsp_word_type  pending [$];
      int            failures;

      function new();
         seg_count     = '0;
         gap_ms        = '0;
         probe_ms      = 16'(PROBE_RESET);
         playing       = 1'b0;
         in_gap        = 1'b0;
         seg_pos       = '0;
         plays_left    = '0;
         due_ms        = '0;
         probe_base_ms = '0;
         drv_ok        = 1'b1;
         run_level     = '0;
         failures      = 0;
         foreach (pattern[i]) pattern[i] = '0;
      endfunction

      // A deadline counts as reached when now - deadline is not negative as a
      // signed 32-bit value, so the comparison survives the wrap of the clock.
      function bit deadline_hit(logic [31:0] now, logic [31:0] dl);
         logic [31:0] diff;
         diff = now - dl;
         return !diff[31];
      endfunction

      function int live_count();
         return (int'(seg_count) > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(seg_count);
      endfunction

      function logic [6:0] begin_segment(logic [31:0] now);
         int slot;
         slot = (int'(seg_pos) < MAX_SEGMENTS) ? int'(seg_pos) : 0;
         due_ms = now + 32'(pattern[slot].duration_ms);
         return pattern[slot].amplitude;
      endfunction

      // True when this word would latch the driver as absent. The stimulus uses
      // it to keep that one-way fault out of the run until its last phase.
      function bit would_fault(req_word_type w);
         if (w.driver_present || !drv_ok) return 1'b0;
         if (w.kind == KIND_START) return !playing;
         if (w.kind == KIND_TICK)
            return playing && deadline_hit(w.now_ms, probe_base_ms + 32'(probe_ms));
         return 1'b0;
      endfunction

      function void note_csr(logic [1:0] index, logic [15:0] data);
         case (index)
            CSR_SEGMENT_COUNT:  seg_count = data[4:0];
            CSR_REPEAT_GAP:     gap_ms    = data;
            CSR_PROBE_INTERVAL: probe_ms  = data;
            default: ;
         endcase
      endfunction

      function void note_request(req_word_type w);
         rsp_word_type r;
         bit           fault;
         r     = '0;
         fault = 1'b0;
         case (w.kind)
            KIND_LOAD: begin
               pattern[w.seg_index].amplitude   =
                  (w.seg_amplitude > AMP_MAX) ? AMP_MAX : w.seg_amplitude;
               pattern[w.seg_index].duration_ms = w.seg_duration_ms;
            end
            KIND_START: begin
               r.status = STAT_REJECTED;
               if (playing) begin
                  r.error = ERR_INVALID;
               end else if (!drv_ok || !w.driver_present) begin
                  drv_ok  = 1'b0;
                  r.error = ERR_DRIVER;
               end else if (live_count() == 0) begin
                  r.error = ERR_INVALID;
               end else begin
                  r.status          = STAT_ACCEPTED;
                  in_gap            = 1'b0;
                  seg_pos           = '0;
                  plays_left        = w.repeat_count;
                  run_level         = w.intensity;
                  probe_base_ms     = w.now_ms;
                  playing           = 1'b1;
                  r.drive_update    = 1'b1;
                  r.drive_amplitude = begin_segment(w.now_ms);
               end
            end
            KIND_TICK: if (playing) begin
               // The probe comes first; a failed probe ends playback without
               // touching the drive.
               if (deadline_hit(w.now_ms, probe_base_ms + 32'(probe_ms))) begin
                  probe_base_ms = w.now_ms;
                  if (!w.driver_present) begin
                     playing  = 1'b0;
                     drv_ok   = 1'b0;
                     r.status = STAT_REJECTED;
                     r.error  = ERR_DRIVER;
                     fault    = 1'b1;
                  end
               end
               if (!fault && deadline_hit(w.now_ms, due_ms)) begin
                  r.drive_update = 1'b1;
                  if (in_gap) begin
                     in_gap            = 1'b0;
                     seg_pos           = '0;
                     r.drive_amplitude = begin_segment(w.now_ms);
                  end else begin
                     seg_pos = seg_pos + 5'd1;
                     if (int'(seg_pos) < live_count()) begin
                        r.drive_amplitude = begin_segment(w.now_ms);
                     end else if (plays_left > 8'd1) begin
                        plays_left = plays_left - 8'd1;
                        in_gap     = 1'b1;
                        due_ms     = w.now_ms + 32'(gap_ms);
                     end else begin
                        playing  = 1'b0;
                        r.status = STAT_COMPLETED;
                     end
                  end
               end
            end
            default: ;
         endcase
         r.drive_intensity = run_level;
         r.playing         = playing;
         pending.push_back(r);
      endfunction

      function void check_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
         end
      endfunction

      function void check_response(rsp_word_type got);
         rsp_word_type want;
         if (pending.size() == 0) begin
            $error("response word %h arrived with nothing expected", got);
            failures++;
            return;
         end
         want = pending.pop_front();
         check_field("status", 32'(want.status), 32'(got.status));
         check_field("error", 32'(want.error), 32'(got.error));
         check_field("drive_update", 32'(want.drive_update), 32'(got.drive_update));
         check_field("drive_amplitude", 32'(want.drive_amplitude),
                     32'(got.drive_amplitude));
         check_field("drive_intensity", 32'(want.drive_intensity),
                     32'(got.drive_intensity));
         check_field("playing", 32'(want.playing), 32'(got.playing));
      endfunction
   endclass

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_word;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [15:0]  csr_wdata;

   hps_scoreboard sb = new();

   // Free-running millisecond clock as the stimulus sees it. It starts just short
   // of the 32-bit wrap so that deadlines straddle it early in the run.
   logic [31:0] clock_ms;
   // Burst flags switch each side between random idling and back-to-back words.
   bit          send_burst = 1'b0;
   bit          sink_burst = 1'b0;
   int          rsp_count  = 0;

   haptic_pattern_sequencer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic req_word_type make_word(logic [1:0] kind, logic [31:0] now,
                                              logic present, logic [7:0] reps,
                                              logic [1:0] level, logic [3:0] slot,
                                              logic [6:0] amp, logic [15:0] dur);
      req_word_type w;
      w.kind            = kind;
      w.now_ms          = now;
      w.driver_present  = present;
      w.repeat_count    = reps;
      w.intensity       = level;
      w.seg_index       = slot;
      w.seg_amplitude   = amp;
      w.seg_duration_ms = dur;
      return w;
   endfunction

   // Draws the next random request word from the predicted playback state.
   // Idle, the mix leans to starts and loads; while playing it leans to ticks,
   // and half of the ticks land on or just past a deadline not yet reached,
   // so patterns run to the end and through their repeat gaps. Fields a kind
   // does not use carry random bits. driver_present is low a quarter of the
   // time, except where that would latch the driver fault; the last phase covers it.
   function automatic req_word_type random_word();
      req_word_type w;
      int unsigned  roll;
      w.repeat_count    = 8'($urandom);
      w.intensity       = 2'($urandom);
      w.seg_index       = 4'($urandom);
      w.seg_amplitude   = 7'($urandom_range(0, 127));
      w.seg_duration_ms = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 24));
      roll = $urandom_range(0, 99);
      if (sb.playing) begin
         w.kind = (roll < 78) ? KIND_TICK : (roll < 88) ? KIND_LOAD :
                  (roll < 96) ? KIND_START : KIND_RESERVED;
      end else begin
         w.kind = (roll < 40) ? KIND_START : (roll < 70) ? KIND_TICK :
                  (roll < 95) ? KIND_LOAD : KIND_RESERVED;
      end
      // Short repeat counts keep patterns finishing within a phase.
      if (w.kind == KIND_START)
         w.repeat_count = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(4, 12))
                                                      : 8'($urandom_range(0, 3));
      if (w.kind == KIND_TICK && sb.playing) begin
         roll = $urandom_range(0, 19);
         if (roll == 0)
            clock_ms = $urandom;
         else if (roll < 11 && !sb.deadline_hit(clock_ms, sb.due_ms))
            clock_ms = sb.due_ms + 32'($urandom_range(0, 2));
         else
            clock_ms = clock_ms + 32'($urandom_range(0, 5));
      end else begin
         clock_ms = clock_ms + 32'($urandom_range(0, 3));
      end
      w.now_ms         = clock_ms;
      w.driver_present = ($urandom_range(0, 3) != 0);
      if (sb.would_fault(w)) w.driver_present = 1'b1;
      return w;
   endfunction

   // Offers one request word after a random gap and returns at the falling edge
   // after it was taken, with valid still high so that a back-to-back word keeps
   // it up. The predictor sees the word at the edge where it was taken.
   task automatic send_word(input req_word_type w);
      int unsigned gap;
      if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word  = w;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_request(w);
      @(negedge clock);
   endtask

   // Register writes go through the same kind of handshake. The caller drops
   // csr_valid after its last write.
   task automatic write_csr(input logic [1:0] index, input logic [15:0] data);
      csr_index = index;
      csr_wdata = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.note_csr(index, data);
      @(negedge clock);
   endtask

   // Stops offering words, waits until every expected response word has come
   // and then lets the two-stage pipeline empty.
   task automatic settle();
      req_valid = 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic set_regs(input logic [15:0] count, input logic [15:0] gap,
                           input logic [15:0] probe);
      write_csr(CSR_SEGMENT_COUNT, count);
      write_csr(CSR_REPEAT_GAP, gap);
      write_csr(CSR_PROBE_INTERVAL, probe);
      csr_valid = 1'b0;
   endtask

   // One setting of the registers followed by a stretch of random words.
   // Playback may still be running when the registers change, so a shrinking
   // segment count ends a pattern early at its next deadline.
   task automatic run_phase(input logic [15:0] count, input logic [15:0] gap,
                            input logic [15:0] probe, input int words);
      settle();
      set_regs(count, gap, probe);
      repeat (words) send_word(random_word());
   endtask

   // Response side: random hold-offs per word, with bursts of none, and one
   // long stall that backs the block up until it refuses request words.
   initial begin : response_sink
      int unsigned hold;
      rsp_ready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0) sink_burst = !sink_burst;
         hold = sink_burst ? 0 : $urandom_range(0, 17);
         if (rsp_count == STALL_AT) hold = LONG_STALL;
         if (hold != 0) begin
            rsp_ready = 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_response(rsp_word);
         rsp_count++;
         @(negedge clock);
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < RUN_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("haptic_pattern_sequencer_tb: errors");
      $finish;
   end

   initial begin : stimulus
      req_valid = 1'b0;
      req_word  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_SEGMENT_COUNT;
      csr_wdata = '0;
      clock_ms  = 32'hFFFF_FF00;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Out of reset no segments are in use. An idle tick and a reserved kind
      // give empty words; a start is refused as invalid. driver_present is low
      // on the idle tick, which must not count as a probe.
      send_word(make_word(KIND_TICK, clock_ms, 1'b0, 8'd0, 2'd0, 4'd0, 7'd0, 16'd0));
      send_word(make_word(KIND_RESERVED, clock_ms, 1'b1, 8'hFF, 2'd3, 4'hF, 7'h7F,
                          16'hFFFF));
      send_word(make_word(KIND_START, clock_ms, 1'b1, 8'd1, 2'd1, 4'd0, 7'd0, 16'd0));

      // Every slot is loaded before any segment count can reach it. The first
      // slots carry the extremes: zero, full, saturating and just-over amplitude,
      // zero and maximal duration.
      send_word(make_word(KIND_LOAD, clock_ms, 1'b1, 8'd0, 2'd0, 4'd0, 7'd0, 16'd0));
      send_word(make_word(KIND_LOAD, clock_ms, 1'b1, 8'd0, 2'd0, 4'd1, 7'd100, 16'd1));
      send_word(make_word(KIND_LOAD, clock_ms, 1'b1, 8'd0, 2'd0, 4'd2, 7'd127,
                          16'hFFFF));
      send_word(make_word(KIND_LOAD, clock_ms, 1'b1, 8'd0, 2'd0, 4'd3, 7'd101, 16'd3));
      for (int s = 4; s < MAX_SEGMENTS; s++)
         send_word(make_word(KIND_LOAD, clock_ms, 1'b1, 8'd0, 2'd0, 4'(s), 7'(s * 6),
                             16'(s)));

      // Three segments, a short gap, and a probe on every tick.
      settle();
      set_regs(16'd3, 16'd2, 16'd0);
      send_word(make_word(KIND_START, clock_ms, 1'b1, 8'd2, 2'd3, 4'd0, 7'd0, 16'd0));
      // A second start while playing is invalid and must not count as a probe.
      send_word(make_word(KIND_START, clock_ms, 1'b0, 8'd5, 2'd0, 4'd0, 7'd0, 16'd0));
      // A load while playing takes effect when its slot next begins, here at once.
      send_word(make_word(KIND_LOAD, clock_ms, 1'b1, 8'd0, 2'd0, 4'd1, 7'd55, 16'd4));
      send_word(make_word(KIND_TICK, clock_ms, 1'b1, 8'd0, 2'd0, 4'd0, 7'd0, 16'd0));
      repeat (220) send_word(random_word());

      run_phase(16'd16, 16'd0, 16'd0, 140);
      run_phase(16'd1, 16'hFFFF, 16'hFFFF, 140);
      run_phase(16'd31, 16'd7, 16'd1, 140);
      run_phase(16'd0, 16'd100, 16'd250, 100);
      // Upper data bits beyond the five of the count are dropped.
      run_phase(16'hFFE5, 16'd3, 16'd2, 140);
      run_phase(16'd17, 16'd1, 16'd5, 140);

      // Let any running pattern finish so the last start is accepted.
      settle();
      while (sb.playing) begin
         clock_ms = sb.deadline_hit(clock_ms, sb.due_ms) ? clock_ms + 32'd1 : sb.due_ms;
         send_word(make_word(KIND_TICK, clock_ms, 1'b1, 8'd0, 2'd0, 4'd0, 7'd0, 16'd0));
      end
      settle();
      set_regs(16'd2, 16'd0, 16'd3);
      write_csr(CSR_UNUSED, 16'hFFFF);
      csr_valid = 1'b0;

      // The driver fault latches until reset, so it comes last: a probe that is
      // not yet due ignores an absent driver, the next due one aborts playback,
      // and from then on every start is refused as a driver fault.
      send_word(make_word(KIND_START, clock_ms, 1'b1, 8'hFF, 2'd2, 4'd0, 7'd0, 16'd0));
      send_word(make_word(KIND_TICK, clock_ms + 32'd1, 1'b0, 8'd0, 2'd0, 4'd0, 7'd0,
                          16'd0));
      send_word(make_word(KIND_TICK, clock_ms + 32'd3, 1'b0, 8'd0, 2'd0, 4'd0, 7'd0,
                          16'd0));
      send_word(make_word(KIND_START, clock_ms + 32'd4, 1'b1, 8'd1, 2'd1, 4'd0, 7'd0,
                          16'd0));
      send_word(make_word(KIND_TICK, clock_ms + 32'd5, 1'b1, 8'd0, 2'd0, 4'd0, 7'd0,
                          16'd0));
      send_word(make_word(KIND_START, clock_ms + 32'd6, 1'b0, 8'd1, 2'd1, 4'd0, 7'd0,
                          16'd0));

      // Drain, then leave time for any stray response word to show up.
      settle();
      repeat (10) @(negedge clock);
      if (sb.failures == 0) begin
         $display("haptic_pattern_sequencer_tb: clean");
      end else begin
         $display("haptic_pattern_sequencer_tb: errors");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/hps_pkg.sv
rtl/core/hps_ctrl.sv
rtl/core/hps_datapath.sv
rtl/core/haptic_pattern_sequencer.sv
verif/haptic_pattern_sequencer_tb.sv
